// ===== rtl/stsp_pkg.sv =====
// ----------------------------------------------------------------------------
// stsp_pkg
// Shared constants for the zoom-out transition pixel source: field widths,
// register indexes, reset values and queue depths.
// ----------------------------------------------------------------------------
package stsp_pkg;

  // Field widths fixed by the interface.
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 1;
  localparam int FIELD_W = 12;
  localparam int INDEX_W = 24;

  // Default largest screen dimension.
  localparam int MAX_DIM_DEF = 4096;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Register values after reset.
  localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd1024;
  localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd768;

  // Queue depths, powers of two.
  localparam int MID_DEPTH = 32;
  localparam int OUT_DEPTH = 32;

endpackage

// ===== rtl/stsp_fifo.sv =====
// ----------------------------------------------------------------------------
// stsp_fifo
// Register-based queue. The owner keeps it from overflowing by credit.
// ----------------------------------------------------------------------------
module stsp_fifo #(
  parameter int DEPTH = stsp_pkg::MID_DEPTH,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [AW:0]      wr_ptr;
  logic [AW:0]      rd_ptr;

  // Pointers carry one extra bit so that full and empty differ.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr[AW-1:0]] <= wr_data;
  end

  assign rd_data = mem[rd_ptr[AW-1:0]];
  assign empty   = (wr_ptr == rd_ptr);

endmodule

// ===== rtl/stsp_div.sv =====
// ----------------------------------------------------------------------------
// stsp_div
// Pipelined restoring divider, one quotient bit per stage, with a tag that
// travels alongside. The pipeline never stalls.
// ----------------------------------------------------------------------------
module stsp_div #(
  parameter int NW = 26,
  parameter int VW = 13,
  parameter int QW = 13,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [NW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [TW-1:0] in_tag,
  output logic          out_valid,
  output logic [QW-1:0] out_quot,
  output logic [TW-1:0] out_tag
);

  localparam int EW = VW + QW;

  logic [QW:0]   vld;
  logic [NW-1:0] rem  [0:QW];
  logic [VW-1:0] dvs  [0:QW];
  logic [QW-1:0] quo  [0:QW];
  logic [TW-1:0] tag  [0:QW];

  assign vld[0] = in_valid;
  assign rem[0] = in_dividend;
  assign dvs[0] = in_divisor;
  assign quo[0] = '0;
  assign tag[0] = in_tag;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int J = QW - 1 - k;
    logic [EW-1:0] trial;
    logic          ge;

    // Try to subtract the divisor shifted to this quotient bit.
    always_comb begin
      trial = EW'(dvs[k]) << J;
      ge    = (EW'(rem[k]) >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else     vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? rem[k] - NW'(trial) : rem[k];
      quo[k+1] <= quo[k] | (QW'(ge) << J);
      dvs[k+1] <= dvs[k];
      tag[k+1] <= tag[k];
    end
  end

  assign out_valid = vld[QW];
  assign out_quot  = quo[QW];
  assign out_tag   = tag[QW];

endmodule

// ===== rtl/stsp_front.sv =====
// ----------------------------------------------------------------------------
// stsp_front
// Front part: takes a step and coordinate, sizes the shrunken window and
// decides whether the pixel falls inside it.
// ----------------------------------------------------------------------------
module stsp_front #(
  parameter int DW = 13,
  parameter int MW = 4 * 13 + 2 * stsp_pkg::FIELD_W + 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [stsp_pkg::FIELD_W-1:0] in_step,
  input  logic [stsp_pkg::FIELD_W-1:0] in_x,
  input  logic [stsp_pkg::FIELD_W-1:0] in_y,
  input  logic [DW-1:0]                dim_w,
  input  logic [DW-1:0]                dim_h,
  output logic                         out_valid,
  output logic [MW-1:0]                out_data
);

  localparam int FW = stsp_pkg::FIELD_W;
  localparam int NW = 2 * DW;
  localparam int CW = (DW > FW ? DW : FW) + 1;
  localparam int TW = 3 * FW;

  logic          a_valid;
  logic [NW-1:0] a_prod;
  logic [TW-1:0] a_tag;

  logic          d_valid;
  logic [DW-1:0] d_quot;
  logic [TW-1:0] d_tag;

  logic [FW-1:0] n, x, y;
  logic [CW-1:0] cn, cx, cy, cw, ch, neww, newh, p, q;
  logic          ok, in_window;
  logic [CW-1:0] dx, dy;

  // Product of step and width, ahead of the width ratio divide.
  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else     a_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    a_prod <= NW'(in_step) * NW'(dim_w);
    a_tag  <= {in_step, in_x, in_y};
  end

  stsp_div #(.NW(NW), .VW(DW), .QW(DW), .TW(TW)) u_div (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (a_valid),
    .in_dividend(a_prod),
    .in_divisor (dim_h),
    .in_tag     (a_tag),
    .out_valid  (d_valid),
    .out_quot   (d_quot),
    .out_tag    (d_tag)
  );

  // Window geometry and the inside test.
  always_comb begin
    {n, x, y} = d_tag;
    cn   = CW'(n);
    cx   = CW'(x);
    cy   = CW'(y);
    cw   = CW'(dim_w);
    ch   = CW'(dim_h);
    neww = cw - CW'(d_quot);
    newh = ch - cn;
    p    = cn >> 1;
    q    = CW'(d_quot) >> 1;
    ok   = (dim_h != '0) && (dim_w != '0) && (cn < ch) && (cx < cw) && (cy < ch);
    in_window = ok && (neww != '0) && (cx >= q) && (cx < q + neww)
                && (cy >= p) && (cy < p + newh);
    dx   = cx - q;
    dy   = cy - p;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= d_valid;
  end

  always_ff @(posedge clk) begin
    out_data <= {in_window, x, y, dx[DW-1:0], dy[DW-1:0], neww[DW-1:0], newh[DW-1:0]};
  end

endmodule

// ===== rtl/stsp_back.sv =====
// ----------------------------------------------------------------------------
// stsp_back
// Back part: scales the window offsets to source coordinates and forms the
// linear source index.
// ----------------------------------------------------------------------------
module stsp_back #(
  parameter int DW = 13,
  parameter int MW = 4 * 13 + 2 * stsp_pkg::FIELD_W + 1,
  parameter int RW = 1 + 2 * stsp_pkg::FIELD_W + stsp_pkg::INDEX_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [MW-1:0] in_data,
  input  logic [DW-1:0] dim_w,
  input  logic [DW-1:0] dim_h,
  output logic          out_valid,
  output logic [RW-1:0] out_data
);

  localparam int FW  = stsp_pkg::FIELD_W;
  localparam int IW  = stsp_pkg::INDEX_W;
  localparam int NW  = 2 * DW;
  localparam int CW  = DW > FW ? DW : FW;
  localparam int SW  = (NW + 1 > IW) ? NW + 1 : IW;
  localparam int TXW = 2 * FW;

  logic          i_first;
  logic [FW-1:0] i_x, i_y;
  logic [DW-1:0] i_dx, i_dy, i_neww, i_newh;

  logic          b_valid;
  logic [NW-1:0] b_mx, b_my;
  logic [DW-1:0] b_neww, b_newh;
  logic          b_first;
  logic [TXW-1:0] b_tag;

  logic          qx_valid, qy_valid;
  logic [DW-1:0] qx, qy;
  logic [TXW-1:0] qx_tag;
  logic          qy_first;

  logic [CW-1:0] sx, sy;
  logic [FW-1:0] o_x, o_y;
  logic [SW-1:0] idx;

  assign {i_first, i_x, i_y, i_dx, i_dy, i_neww, i_newh} = in_data;

  // Offsets times the full dimensions.
  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else     b_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    b_mx    <= NW'(dim_w) * NW'(i_dx);
    b_my    <= NW'(dim_h) * NW'(i_dy);
    b_neww  <= i_neww;
    b_newh  <= i_newh;
    b_first <= i_first;
    b_tag   <= {i_x, i_y};
  end

  stsp_div #(.NW(NW), .VW(DW), .QW(DW), .TW(TXW)) u_div_x (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (b_valid),
    .in_dividend(b_mx),
    .in_divisor (b_neww),
    .in_tag     (b_tag),
    .out_valid  (qx_valid),
    .out_quot   (qx),
    .out_tag    (qx_tag)
  );

  stsp_div #(.NW(NW), .VW(DW), .QW(DW), .TW(1)) u_div_y (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (b_valid),
    .in_dividend(b_my),
    .in_divisor (b_newh),
    .in_tag     (b_first),
    .out_valid  (qy_valid),
    .out_quot   (qy),
    .out_tag    (qy_first)
  );

  // Pick scaled or unscaled coordinates and build the index.
  always_comb begin
    {o_x, o_y} = qx_tag;
    sx  = qy_first ? CW'(qx) : CW'(o_x);
    sy  = qy_first ? CW'(qy) : CW'(o_y);
    idx = SW'(SW'(sy) * SW'(dim_w)) + SW'(sx);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= qx_valid && qy_valid;
  end

  always_ff @(posedge clk) begin
    out_data <= {qy_first, sx[FW-1:0], sy[FW-1:0], idx[IW-1:0]};
  end

endmodule

// ===== rtl/shrink_transition_pixel_source_unit.sv =====
// ----------------------------------------------------------------------------
// shrink_transition_pixel_source_unit
// Throughput: one pixel per cycle while the result side keeps popping.
// Reset (rst, synchronous): queues and pipelines empty, width 1024, height 768.
// Front and back parts run on their own credits across a 32-entry queue.
// ----------------------------------------------------------------------------
module shrink_transition_pixel_source_unit #(
  parameter int MAX_DIM = stsp_pkg::MAX_DIM_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [stsp_pkg::FIELD_W-1:0] step,
  input  logic [stsp_pkg::FIELD_W-1:0] pix_x,
  input  logic [stsp_pkg::FIELD_W-1:0] pix_y,
  output logic                         empty,
  input  logic                         pop,
  output logic                         from_first,
  output logic [stsp_pkg::FIELD_W-1:0] src_x,
  output logic [stsp_pkg::FIELD_W-1:0] src_y,
  output logic [stsp_pkg::INDEX_W-1:0] src_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [stsp_pkg::IDX_W-1:0]   cfg_index,
  input  logic [stsp_pkg::CFG_W-1:0]   cfg_data
);

  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int FW    = stsp_pkg::FIELD_W;
  localparam int MW    = 4 * DW + 2 * FW + 1;
  localparam int RW    = 1 + 2 * FW + stsp_pkg::INDEX_W;
  localparam int CMP_W = stsp_pkg::CFG_W > DW ? stsp_pkg::CFG_W : DW;
  localparam int MD    = stsp_pkg::MID_DEPTH;
  localparam int OD    = stsp_pkg::OUT_DEPTH;
  localparam int MCW   = $clog2(MD + 1);
  localparam int OCW   = $clog2(OD + 1);

  logic [stsp_pkg::CFG_W-1:0] screen_width, screen_height;
  logic [DW-1:0]              dim_w, dim_h;

  logic          accept, mid_pop, out_pop;
  logic          f_valid, b_valid, mid_empty;
  logic [MW-1:0] f_data, mid_data;
  logic [RW-1:0] b_data, out_data;
  logic [MCW-1:0] front_cnt;
  logic [OCW-1:0] back_cnt;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= stsp_pkg::RESET_WIDTH;
      screen_height <= stsp_pkg::RESET_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        stsp_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        stsp_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Dimensions saturate at the largest supported size.
  assign dim_w = (CMP_W'(screen_width) > CMP_W'(MAX_DIM)) ? DW'(MAX_DIM)
                                                          : DW'(screen_width);
  assign dim_h = (CMP_W'(screen_height) > CMP_W'(MAX_DIM)) ? DW'(MAX_DIM)
                                                           : DW'(screen_height);

  // Credits: each count covers a pipeline in flight plus the queue behind it.
  assign full    = (front_cnt == MCW'(MD));
  assign accept  = push && !full;
  assign mid_pop = !mid_empty && (back_cnt != OCW'(OD));
  assign out_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_cnt <= '0;
      back_cnt  <= '0;
    end else begin
      front_cnt <= front_cnt + MCW'(accept) - MCW'(mid_pop);
      back_cnt  <= back_cnt + OCW'(mid_pop) - OCW'(out_pop);
    end
  end

  stsp_front #(.DW(DW), .MW(MW)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .in_step  (step),
    .in_x     (pix_x),
    .in_y     (pix_y),
    .dim_w    (dim_w),
    .dim_h    (dim_h),
    .out_valid(f_valid),
    .out_data (f_data)
  );

  stsp_fifo #(.DEPTH(MD), .WIDTH(MW)) u_mid_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (f_valid),
    .wr_data(f_data),
    .rd_en  (mid_pop),
    .rd_data(mid_data),
    .empty  (mid_empty)
  );

  stsp_back #(.DW(DW), .MW(MW), .RW(RW)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mid_pop),
    .in_data  (mid_data),
    .dim_w    (dim_w),
    .dim_h    (dim_h),
    .out_valid(b_valid),
    .out_data (b_data)
  );

  stsp_fifo #(.DEPTH(OD), .WIDTH(RW)) u_out_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (b_valid),
    .wr_data(b_data),
    .rd_en  (out_pop),
    .rd_data(out_data),
    .empty  (empty)
  );

  assign {from_first, src_x, src_y, src_index} = out_data;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Zoom-out transition pixel source testbench
// Streams step and screen-coordinate beats into the block under several screen
// sizes and compares every result against an in-line prediction of the
// shrunken-window mapping, oldest expectation first.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FIELD_W = stsp_pkg::FIELD_W;
  localparam int INDEX_W = stsp_pkg::INDEX_W;
  localparam int IDX_W   = stsp_pkg::IDX_W;
  localparam int CFG_W   = stsp_pkg::CFG_W;

  localparam int DRAIN_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [FIELD_W-1:0] step;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } pixel_req_t;

  typedef struct packed {
    logic               first;
    logic [FIELD_W-1:0] sx;
    logic [FIELD_W-1:0] sy;
    logic [INDEX_W-1:0] idx;
  } pixel_src_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [FIELD_W-1:0] step = '0;
  logic [FIELD_W-1:0] pix_x = '0;
  logic [FIELD_W-1:0] pix_y = '0;
  logic empty;
  logic pop = 1'b0;
  logic from_first;
  logic [FIELD_W-1:0] src_x;
  logic [FIELD_W-1:0] src_y;
  logic [INDEX_W-1:0] src_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  pixel_req_t pending_pixels[$];
  pixel_src_t expected_sources[$];
  logic [CFG_W-1:0] cur_width = stsp_pkg::RESET_WIDTH;
  logic [CFG_W-1:0] cur_height = stsp_pkg::RESET_HEIGHT;
  int send_idle_pct = 35;
  int recv_idle_pct = 73;
  int errors = 0;
  int idle_cycles = 0;

  shrink_transition_pixel_source_unit dut (.*);

  always #4 clk = ~clk;

  // Predict where one screen pixel is sourced from.
  function automatic pixel_src_t map_pixel(pixel_req_t r);
    pixel_src_t o;
    longint unsigned w, h, n, x, y, sx, sy, nw, nh, p, q;
    w = (cur_width > 4096) ? 4096 : cur_width;
    h = (cur_height > 4096) ? 4096 : cur_height;
    n = r.step;
    x = r.x;
    y = r.y;
    sx = x;
    sy = y;
    o.first = 1'b0;
    if (h != 0 && w != 0 && n < h && x < w && y < h) begin
      nh = h - n;
      nw = w - (n * w) / h;
      p = n / 2;
      q = (w - nw) / 2;
      if (nw != 0 && x >= q && x < q + nw && y >= p && y < p + nh) begin
        o.first = 1'b1;
        sx = (w * (x - q)) / nw;
        sy = (h * (y - p)) / nh;
      end
    end
    o.sx = sx[FIELD_W-1:0];
    o.sy = sy[FIELD_W-1:0];
    o.idx = INDEX_W'(sy * w + sx);
    return o;
  endfunction

  // Driver: presents queued pixel beats, idling at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        expected_sources.push_back(map_pixel({step, pix_x, pix_y}));
        void'(pending_pixels.pop_front());
      end
      if ((!push || !full) && pending_pixels.size() > 0
          && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        {step, pix_x, pix_y} <= pending_pixels[0];
      end else if (!push || !full) begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: checks each popped result and pulls pop at random.
  always @(posedge clk) begin
    pixel_src_t want;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_sources.size() == 0) begin
          $error("unexpected result beat");
          errors++;
        end else begin
          want = expected_sources.pop_front();
          if (from_first !== want.first) begin
            $error("from_first: expected %0d, got %0d", want.first, from_first);
            errors++;
          end
          if (src_x !== want.sx) begin
            $error("src_x: expected %0d, got %0d", want.sx, src_x);
            errors++;
          end
          if (src_y !== want.sy) begin
            $error("src_y: expected %0d, got %0d", want.sy, src_y);
            errors++;
          end
          if (src_index !== want.idx) begin
            $error("src_index: expected %0d, got %0d", want.idx, src_index);
            errors++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: counts cycles with no accepted beat on any channel.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("shrink_transition_pixel_source_unit: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == stsp_pkg::REG_SCREEN_WIDTH) cur_width = val;
    else cur_height = val;
  endtask

  task automatic queue_pixel(int n, int x, int y);
    pixel_req_t r;
    r.step = FIELD_W'(n);
    r.x = FIELD_W'(x);
    r.y = FIELD_W'(y);
    pending_pixels.push_back(r);
  endtask

  // Waits until every queued beat has gone out and every result has come back.
  task automatic drain();
    while (pending_pixels.size() != 0 || push || expected_sources.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random pixels, mostly on screen and with steps below the height.
  task automatic random_pixels(int count);
    int w, h;
    w = (cur_width > 4096) ? 4096 : cur_width;
    h = (cur_height > 4096) ? 4096 : cur_height;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8 && w > 0 && h > 0)
        queue_pixel($urandom_range(h - 1), $urandom_range(w - 1), $urandom_range(h - 1));
      else
        queue_pixel($urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] widths[6] = '{13'd1024, 13'd4096, 13'd1, 13'd8191, 13'd37, 13'd0};
    logic [CFG_W-1:0] heights[6] = '{13'd768, 13'd4096, 13'd1, 13'd8191, 13'd23, 13'd5};
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed beats at reset size: corners, window edges, step past height.
    queue_pixel(0, 0, 0);
    queue_pixel(0, 1023, 767);
    queue_pixel(767, 511, 383);
    queue_pixel(768, 10, 10);
    queue_pixel(4095, 4095, 4095);
    queue_pixel(100, 0, 50);
    queue_pixel(100, 66, 50);
    queue_pixel(100, 67, 50);
    queue_pixel(100, 957, 718);
    queue_pixel(100, 958, 400);
    queue_pixel(100, 500, 717);
    queue_pixel(100, 500, 49);
    queue_pixel(0, 1024, 0);
    queue_pixel(0, 0, 768);
    queue_pixel(2730, 2730, 1365);
    queue_pixel(1365, 1365, 2730);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph / 2 == 0) ? 35 : (ph / 2 == 1) ? 73 : 0;
      recv_idle_pct = (ph / 2 == 0) ? 73 : (ph / 2 == 1) ? 35 : 0;
      write_reg(stsp_pkg::REG_SCREEN_WIDTH, widths[ph]);
      write_reg(stsp_pkg::REG_SCREEN_HEIGHT, heights[ph]);
      random_pixels(330);
      drain();
    end

    if (errors == 0) begin
      $display("shrink_transition_pixel_source_unit: match");
    end else begin
      $display("shrink_transition_pixel_source_unit: mismatch");
    end
    $finish;
  end
endmodule
